// ===== rtl/core/lphm_pkg.sv =====
// ----------------------------------------------------------------------------
// lphm_pkg
// Shared types and constants of the linear probing hash map unit.
// ----------------------------------------------------------------------------
package lphm_pkg;

	// number of slots, a power of two
	localparam int SLOTS   = 256;
	localparam int IDX_W   = $clog2(SLOTS);
	localparam int LIMIT_W = 8;
	localparam int CNT_W   = LIMIT_W + 1;
	localparam int KEY_W   = 32;
	localparam int VAL_W   = 64;
	localparam int SIDX_W  = 8;
	localparam int STAT_W  = 3;

	localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(192);

	localparam logic MODE_GET = 1'b0;
	localparam logic MODE_SET = 1'b1;

	localparam logic [STAT_W-1:0] ST_MISS     = 3'd0;
	localparam logic [STAT_W-1:0] ST_HIT      = 3'd1;
	localparam logic [STAT_W-1:0] ST_UPDATED  = 3'd2;
	localparam logic [STAT_W-1:0] ST_INSERTED = 3'd3;
	localparam logic [STAT_W-1:0] ST_FULL     = 3'd4;

	typedef struct packed {
		logic             mode;
		logic [KEY_W-1:0] key_hash;
		logic [VAL_W-1:0] value_in;
	} req_t;

	typedef struct packed {
		logic [STAT_W-1:0] status;
		logic [VAL_W-1:0]  value_out;
		logic [SIDX_W-1:0] slot_index;
	} rsp_t;

	typedef struct packed {
		logic             key_en;
		logic             val_en;
		logic [IDX_W-1:0] addr;
		logic [KEY_W-1:0] key;
		logic [VAL_W-1:0] value;
	} mem_wr_t;

endpackage

// ===== rtl/core/lphm_slot_mem.sv =====
// ----------------------------------------------------------------------------
// lphm_slot_mem
// Key and value store of the slots, one write port and one registered read.
// ----------------------------------------------------------------------------
module lphm_slot_mem (
	input  logic                        clk,
	input  logic [lphm_pkg::IDX_W-1:0]  rd_addr,
	output logic [lphm_pkg::KEY_W-1:0]  rd_key,
	output logic [lphm_pkg::VAL_W-1:0]  rd_val,
	input  lphm_pkg::mem_wr_t           wr
);

	logic [lphm_pkg::KEY_W-1:0] key_mem [lphm_pkg::SLOTS];
	logic [lphm_pkg::VAL_W-1:0] val_mem [lphm_pkg::SLOTS];

	always_ff @(posedge clk) begin
		if (wr.key_en) begin
			key_mem[wr.addr] <= wr.key;
		end
		if (wr.val_en) begin
			val_mem[wr.addr] <= wr.value;
		end
		rd_key <= key_mem[rd_addr];
		rd_val <= val_mem[rd_addr];
	end

endmodule

// ===== rtl/core/lphm_probe_ctrl.sv =====
// ----------------------------------------------------------------------------
// lphm_probe_ctrl
// Probe sequencer: walks the slots one per cycle, holds valid bits and count.
// ----------------------------------------------------------------------------
module lphm_probe_ctrl (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          req_valid,
	output logic                          req_stall,
	input  lphm_pkg::req_t                req,
	input  logic [lphm_pkg::LIMIT_W-1:0]  limit,
	input  logic                          out_free,
	output logic                          push,
	output lphm_pkg::rsp_t                rsp,
	output logic [lphm_pkg::IDX_W-1:0]    rd_addr,
	input  logic [lphm_pkg::KEY_W-1:0]    rd_key,
	input  logic [lphm_pkg::VAL_W-1:0]    rd_val,
	output lphm_pkg::mem_wr_t             wr
);

	typedef enum logic [1:0] {IDLE, PROBE, HOLD} state_t;

	state_t                       state_q;
	logic [lphm_pkg::IDX_W-1:0]   idx_q;
	logic [lphm_pkg::IDX_W-1:0]   nprobe_q;
	logic [lphm_pkg::CNT_W-1:0]   count_q;
	logic [lphm_pkg::SLOTS-1:0]   valid_q;
	lphm_pkg::req_t               req_q;
	lphm_pkg::rsp_t               res_q;

	logic                         accept;
	logic [lphm_pkg::IDX_W-1:0]   idx_nx;
	logic                         slot_used;
	logic                         stop;
	logic                         last;
	logic                         done;
	logic [lphm_pkg::IDX_W-1:0]   where;
	logic                         room;
	logic                         ins;
	lphm_pkg::rsp_t               dec;

	assign accept    = req_valid && (state_q == IDLE);
	assign req_stall = (state_q != IDLE);
	assign idx_nx    = idx_q + 1'b1;
	assign slot_used = valid_q[idx_q];
	assign stop      = !slot_used || (rd_key == req_q.key_hash);
	assign last      = (nprobe_q == '1);
	assign done      = (state_q == PROBE) && (stop || last);
	// an exhausted probe wraps back to its start slot
	assign where     = stop ? idx_q : idx_nx;
	assign room      = (count_q < lphm_pkg::CNT_W'(limit));
	assign ins       = done && (req_q.mode == lphm_pkg::MODE_SET) && stop && !slot_used
		&& room;

	always_comb begin
		dec.value_out  = '0;
		dec.slot_index = lphm_pkg::SIDX_W'(where);
		if (req_q.mode == lphm_pkg::MODE_GET) begin
			if (stop && slot_used) begin
				dec.status    = lphm_pkg::ST_HIT;
				dec.value_out = rd_val;
			end else begin
				dec.status = lphm_pkg::ST_MISS;
			end
		end else if (!stop) begin
			dec.status = lphm_pkg::ST_FULL;
		end else if (slot_used) begin
			dec.status = lphm_pkg::ST_UPDATED;
		end else if (!room) begin
			dec.status = lphm_pkg::ST_FULL;
		end else begin
			dec.status = lphm_pkg::ST_INSERTED;
		end
	end

	always_comb begin
		wr.key_en = ins;
		wr.val_en = ins || (done && (req_q.mode == lphm_pkg::MODE_SET) && stop && slot_used);
		wr.addr   = where;
		wr.key    = req_q.key_hash;
		wr.value  = req_q.value_in;
	end

	// the next slot is read ahead while the current one is checked
	always_comb begin
		unique case (state_q)
			IDLE:    rd_addr = req.key_hash[lphm_pkg::IDX_W-1:0];
			PROBE:   rd_addr = idx_nx;
			default: rd_addr = idx_q;
		endcase
	end

	assign push = out_free && (done || (state_q == HOLD));
	assign rsp  = (state_q == HOLD) ? res_q : dec;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= IDLE;
			idx_q    <= '0;
			nprobe_q <= '0;
			count_q  <= '0;
			valid_q  <= '0;
		end else begin
			if (ins) begin
				valid_q[where] <= 1'b1;
				count_q        <= count_q + 1'b1;
			end
			unique case (state_q)
				IDLE: begin
					if (accept) begin
						idx_q    <= req.key_hash[lphm_pkg::IDX_W-1:0];
						nprobe_q <= '0;
						state_q  <= PROBE;
					end
				end
				PROBE: begin
					if (done) begin
						state_q <= out_free ? IDLE : HOLD;
					end else begin
						idx_q    <= idx_nx;
						nprobe_q <= nprobe_q + 1'b1;
					end
				end
				HOLD: begin
					if (out_free) begin
						state_q <= IDLE;
					end
				end
				default: state_q <= IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			req_q <= req;
		end
		if (done) begin
			res_q <= dec;
		end
	end

endmodule

// ===== rtl/core/linear_probe_hash_map_unit.sv =====
// ----------------------------------------------------------------------------
// linear_probe_hash_map_unit
// Open addressing map with linear probing over a key/value slot memory.
// ----------------------------------------------------------------------------
// a request probes P slots, P = 1..256, one slot per cycle through the single memory
//   read port; the unit takes no new request while a probe is in progress
// a new request is taken while the previous result waits in the output register
// reset clears all slot valid bits and the entry count at once, load limit is 192;
//   key and value memory contents are not cleared
// ----------------------------------------------------------------------------
module linear_probe_hash_map_unit (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          req_valid,
	output logic                          req_stall,
	input  lphm_pkg::req_t                req,
	output logic                          rsp_valid,
	input  logic                          rsp_stall,
	output lphm_pkg::rsp_t                rsp,
	input  logic                          cfg_we,
	input  logic [lphm_pkg::LIMIT_W-1:0]  cfg_wdata
);

	logic [lphm_pkg::LIMIT_W-1:0] limit_q;
	logic                         rsp_valid_q;
	lphm_pkg::rsp_t               rsp_q;

	logic                         out_free;
	logic                         push;
	lphm_pkg::rsp_t               res;
	logic [lphm_pkg::IDX_W-1:0]   rd_addr;
	logic [lphm_pkg::KEY_W-1:0]   rd_key;
	logic [lphm_pkg::VAL_W-1:0]   rd_val;
	lphm_pkg::mem_wr_t            wr;

	assign out_free  = !rsp_valid_q || !rsp_stall;
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q     <= lphm_pkg::LIMIT_RESET;
			rsp_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				limit_q <= cfg_wdata;
			end
			if (out_free) begin
				rsp_valid_q <= push;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			rsp_q <= res;
		end
	end

	lphm_probe_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.limit     (limit_q),
		.out_free  (out_free),
		.push      (push),
		.rsp       (res),
		.rd_addr   (rd_addr),
		.rd_key    (rd_key),
		.rd_val    (rd_val),
		.wr        (wr)
	);

	lphm_slot_mem u_mem (
		.clk     (clk),
		.rd_addr (rd_addr),
		.rd_key  (rd_key),
		.rd_val  (rd_val),
		.wr      (wr)
	);

endmodule

// ===== rtl/core/lphm_checker.sv =====
// ----------------------------------------------------------------------------
// lphm_checker
// Port level checks of the hash map unit, bound to the top level.
// ----------------------------------------------------------------------------
module lphm_checker (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          req_valid,
	input  logic                          req_stall,
	input  lphm_pkg::req_t                req,
	input  logic                          rsp_valid,
	input  logic                          rsp_stall,
	input  lphm_pkg::rsp_t                rsp,
	input  logic                          cfg_we,
	input  logic [lphm_pkg::LIMIT_W-1:0]  cfg_wdata
);

	// a stalled result word holds
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
		else $error("result word changed while stalled");

	// one request in flight: the unit stalls right after taking a word
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && !req_stall |=> req_stall)
		else $error("request accepted while another is in flight");

	// value only returned on a get hit
	a_value_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (rsp.status != lphm_pkg::ST_HIT) |-> (rsp.value_out == '0))
		else $error("nonzero value on a result other than a hit");

	// a result never shows up in the cycle right after a request is taken
	a_min_latency: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && !req_stall && !rsp_valid |=> !rsp_valid)
		else $error("result appeared too early");

endmodule

bind linear_probe_hash_map_unit lphm_checker u_lphm_checker (.*);
